/* rtl/vnoc_pkg.sv */
// ----------------------------------------------------------------------------
// vnoc_pkg
// Shared types, hash constants and the cosine weight table generator for the
// value noise pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vnoc_pkg;

    typedef enum logic [1:0] {
        CFG_ZOOM        = 2'd0,
        CFG_PERSISTENCE = 2'd1,
        CFG_OCTAVES     = 2'd2
    } t_cfg_reg;

    localparam logic [15:0] ZOOM_RESET        = 16'd256;
    localparam logic [15:0] PERSISTENCE_RESET = 16'd8192;
    localparam logic [4:0]  OCTAVES_RESET     = 5'd8;

    localparam logic [31:0] HASH_MUL_Y = 32'd57;
    localparam int          HASH_SHL   = 13;
    localparam logic [31:0] HASH_MUL   = 32'd60493;
    localparam logic [31:0] HASH_ADD_A = 32'd19990303;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;

    localparam logic [30:0] AMP_ONE = 31'd16384;
    localparam logic [30:0] AMP_CAP = 31'h4000_0000;
    localparam int          AMP_FRAC = 14;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // shift-and-subtract long division, evaluated while building the table
    function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // (1 - cos(pi*k/N)) / 2 in Q.f, upper half mirrored from the lower half
    function automatic logic [24:0] wtab_entry(input int k_in, input int tb, input int f);
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned f30;
        longint unsigned e;
        longint          c;
        int              k;
        int              n;
        int              nn;
        bit              mirror;
        mirror = (k_in > (1 << (tb - 1)));
        k = mirror ? ((1 << tb) - k_in) : k_in;
        theta = (PI_Q30 * longint'(k)) >> tb;
        t2 = (theta * theta) >> 30;
        term = ONE_Q30;
        c = longint'(ONE_Q30);
        for (n = 1; n <= 11; n++) begin
            nn = (2 * n - 1) * (2 * n);
            term = udiv_u64((term * t2) >> 30, 64'(nn));
            if ((n & 1) == 1) c = c - longint'(term);
            else c = c + longint'(term);
        end
        if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
        f30 = longint'(longint'(ONE_Q30) - c) >> 1;
        e = (f30 + (64'd1 << (29 - f))) >> (30 - f);
        if (mirror) e = (64'd1 << f) - e;
        return e[24:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/vnoc_div.sv */
// ----------------------------------------------------------------------------
// vnoc_div
// Pipelined restoring divider: |p| * 2^SH / z, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnoc_div #(
    parameter int QW = 50,
    parameter int SH = 34
) (
    input  wire logic              i_clk,
    input  wire logic [15:0]       i_z,
    input  wire logic signed [15:0] i_p,
    output logic      [QW-1:0]     o_q,
    output logic                   o_neg
);

    logic [15:0]   w_mag;
    logic [16:0]   r_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic [15:0]   r_m   [QW];
    logic          r_s   [QW];

    assign w_mag = i_p[15] ? 16'(~i_p + 16'sd1) : i_p;

    for (genvar gi = 0; gi < QW; gi++) begin : g_st
        logic [16:0]   w_rin;
        logic [QW-1:0] w_qin;
        logic [15:0]   w_min;
        logic          w_sin;
        logic [16:0]   w_t;
        logic          w_ge;

        if (gi == 0) begin : g_first
            assign w_rin = '0;
            assign w_qin = '0;
            assign w_min = w_mag;
            assign w_sin = i_p[15];
        end else begin : g_next
            assign w_rin = r_rem[gi-1];
            assign w_qin = r_q[gi-1];
            assign w_min = r_m[gi-1];
            assign w_sin = r_s[gi-1];
        end

        assign w_t  = {w_rin[15:0], w_min[15]};
        assign w_ge = (w_t >= {1'b0, i_z});

        always_ff @(posedge i_clk) begin
            r_rem[gi] <= w_ge ? (w_t - {1'b0, i_z}) : w_t;
            r_q[gi]   <= {w_qin[QW-2:0], w_ge};
            r_m[gi]   <= {w_min[14:0], 1'b0};
            r_s[gi]   <= w_sin;
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_neg = r_s[QW-1];

    localparam int NUM_BITS = 16 + SH;
    if (NUM_BITS != QW) begin : g_bad_width
        $error("vnoc_div: QW must equal 16 + SH");
    end

endmodule

`default_nettype wire

/* rtl/vnoc_hash.sv */
// ----------------------------------------------------------------------------
// vnoc_hash
// Four-stage lattice corner hash, returning the corner level in Q.F.
// ----------------------------------------------------------------------------
`default_nettype none

module vnoc_hash #(
    parameter int F = 16
) (
    input  wire logic              i_clk,
    input  wire logic [31:0]       i_cx,
    input  wire logic [31:0]       i_cy,
    output logic signed [F+1:0]    o_val
);

    logic [31:0] w_n0;
    logic [31:0] w_n1;
    logic [31:0] r_n;
    logic [31:0] r_nn;
    logic [31:0] r_n1;
    logic [31:0] r_t;
    logic [31:0] r_n2;
    logic [31:0] w_m;
    logic [F+1:0] w_one;
    logic [F+1:0] w_sh;
    logic signed [F+1:0] r_val;

    assign w_n0 = i_cx + 32'(i_cy * vnoc_pkg::HASH_MUL_Y);
    assign w_n1 = (w_n0 << vnoc_pkg::HASH_SHL) ^ w_n0;

    always_ff @(posedge i_clk) begin
        r_n  <= w_n1;
        r_nn <= 32'(r_n * r_n);
        r_n1 <= r_n;
        r_t  <= 32'(r_nn * vnoc_pkg::HASH_MUL) + vnoc_pkg::HASH_ADD_A;
        r_n2 <= r_n1;
        r_val <= signed'(w_one - w_sh);
    end

    assign w_m   = (32'(r_n2 * r_t) + vnoc_pkg::HASH_ADD_B) & vnoc_pkg::HASH_MASK;
    assign w_one = (F+2)'(1) << F;
    assign w_sh  = (F+2)'(w_m >> (30 - F));
    assign o_val = r_val;

endmodule

`default_nettype wire

/* rtl/vnoc_oct.sv */
// ----------------------------------------------------------------------------
// vnoc_oct
// One octave: lattice cell split, four corner hashes, cosine blend and
// amplitude weighting. Eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vnoc_oct #(
    parameter int F   = 16,
    parameter int TB  = 8,
    parameter int QW  = 50,
    parameter int SHR = 14,
    parameter int CW  = F + 2,
    parameter int TW  = CW + 18
) (
    input  wire logic                 i_clk,
    input  wire logic [QW-1:0]        i_qx,
    input  wire logic [QW-1:0]        i_qy,
    input  wire logic                 i_nx,
    input  wire logic                 i_ny,
    input  wire logic [30:0]          i_amp,
    input  wire logic                 i_en,
    output logic signed [TW-1:0]      o_term
);

    localparam int N = 1 << TB;

    logic [F:0]         w_tab [N];
    logic [QW+31:0]     w_ex;
    logic [QW+31:0]     w_ey;
    logic [31:0]        w_cellx;
    logic [31:0]        w_celly;
    logic [F+TB-1:0]    w_fzx;
    logic [F+TB-1:0]    w_fzy;
    logic [31:0]        r_cx;
    logic [31:0]        r_cy;
    logic [F:0]         r_wx;
    logic [F:0]         r_wy;
    logic [F:0]         r_wx_d [4];
    logic [F:0]         r_wy_d [5];
    logic signed [CW-1:0] w_c00;
    logic signed [CW-1:0] w_c10;
    logic signed [CW-1:0] w_c01;
    logic signed [CW-1:0] w_c11;
    logic signed [CW:0]   w_d0;
    logic signed [CW:0]   w_d1;
    logic signed [CW+F+2:0] w_p0;
    logic signed [CW+F+2:0] w_p1;
    logic signed [CW-1:0] r_r1;
    logic signed [CW-1:0] r_r2;
    logic signed [CW:0]   w_dy;
    logic signed [CW+F+2:0] w_py;
    logic signed [CW-1:0] r_noise;
    logic signed [CW+31:0] w_pt;
    logic signed [TW-1:0] r_term;

    for (genvar gk = 0; gk < N; gk++) begin : g_tab
        localparam logic [F:0] W_ENTRY = (F+1)'(vnoc_pkg::wtab_entry(gk, TB, F));
        assign w_tab[gk] = W_ENTRY;
    end

    assign w_ex    = {32'd0, i_qx} >> SHR;
    assign w_ey    = {32'd0, i_qy} >> SHR;
    assign w_cellx = w_ex[F+31:F];
    assign w_celly = w_ey[F+31:F];
    assign w_fzx   = {w_ex[F-1:0], {TB{1'b0}}};
    assign w_fzy   = {w_ey[F-1:0], {TB{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_cx <= i_nx ? (32'd0 - w_cellx) : w_cellx;
        r_cy <= i_ny ? (32'd0 - w_celly) : w_celly;
        r_wx <= w_tab[w_fzx[F+TB-1:F]];
        r_wy <= w_tab[w_fzy[F+TB-1:F]];
    end

    vnoc_hash #(.F(F)) u_h00 (.i_clk(i_clk), .i_cx(r_cx),         .i_cy(r_cy),
                              .o_val(w_c00));
    vnoc_hash #(.F(F)) u_h10 (.i_clk(i_clk), .i_cx(r_cx + 32'd1), .i_cy(r_cy),
                              .o_val(w_c10));
    vnoc_hash #(.F(F)) u_h01 (.i_clk(i_clk), .i_cx(r_cx),         .i_cy(r_cy + 32'd1),
                              .o_val(w_c01));
    vnoc_hash #(.F(F)) u_h11 (.i_clk(i_clk), .i_cx(r_cx + 32'd1), .i_cy(r_cy + 32'd1),
                              .o_val(w_c11));

    always_ff @(posedge i_clk) begin
        r_wx_d[0] <= r_wx;
        r_wy_d[0] <= r_wy;
        for (int i = 1; i < 4; i++) r_wx_d[i] <= r_wx_d[i-1];
        for (int i = 1; i < 5; i++) r_wy_d[i] <= r_wy_d[i-1];
    end

    assign w_d0 = (CW+1)'(w_c10) - (CW+1)'(w_c00);
    assign w_d1 = (CW+1)'(w_c11) - (CW+1)'(w_c01);
    assign w_p0 = w_d0 * $signed({1'b0, r_wx_d[3]});
    assign w_p1 = w_d1 * $signed({1'b0, r_wx_d[3]});

    assign w_dy = (CW+1)'(r_r2) - (CW+1)'(r_r1);
    assign w_py = w_dy * $signed({1'b0, r_wy_d[4]});

    assign w_pt = r_noise * $signed({1'b0, i_amp});

    always_ff @(posedge i_clk) begin
        r_r1    <= w_c00 + CW'(w_p0 >>> F);
        r_r2    <= w_c01 + CW'(w_p1 >>> F);
        r_noise <= r_r1 + CW'(w_py >>> F);
        r_term  <= i_en ? TW'(w_pt >>> vnoc_pkg::AMP_FRAC) : '0;
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

/* rtl/value_noise_octave_pixel_top.sv */
// ----------------------------------------------------------------------------
// value_noise_octave_pixel_top
// Multi-octave 2D value noise, one pixel in and one 8-bit level out per clock.
// ----------------------------------------------------------------------------
// A pixel is taken at every clock edge with start high and busy low (busy is
// only high in reset); its level is on o_level with o_valid high for a single
// cycle once it has passed through the bit-per-stage coordinate divider,
// eight octave stages, the octave summing chain and the output stage.
// Results cannot be held off; a new pixel may follow every cycle. Write
// configuration only when no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_octave_pixel_top #(
    parameter int MAX_OCTAVES    = 16,
    parameter int COS_TABLE_BITS = 8,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_px,
    input  wire logic signed [15:0] i_py,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [7:0]              o_level
);

    localparam int F   = FRACTION_BITS;
    localparam int NO  = MAX_OCTAVES - 1;
    localparam int SH  = 4 + F + MAX_OCTAVES - 2;
    localparam int QW  = 16 + SH;
    localparam int CW  = F + 2;
    localparam int TW  = CW + 18;
    localparam int SW  = TW + 5;
    localparam int VW  = SW + 8;
    localparam int LAT = QW + 8 + NO + 1;

    logic [15:0]  r_zoom;
    logic [15:0]  r_pers;
    logic [4:0]   r_oct;
    logic [15:0]  w_z;
    logic [5:0]   w_lim;
    logic [5:0]   w_cnt;
    logic         w_accept;
    logic [QW-1:0] w_qx;
    logic [QW-1:0] w_qy;
    logic         w_nx;
    logic         w_ny;
    logic [30:0]  w_amp [NO];
    logic signed [TW-1:0] w_term [NO];
    logic signed [TW-1:0] r_tt  [NO][NO];
    logic signed [SW-1:0] r_acc [NO];
    logic signed [VW-1:0] w_v;
    logic signed [VW-1:0] w_q;
    logic [7:0]   r_level;
    logic [LAT-1:0] r_vld;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom <= vnoc_pkg::ZOOM_RESET;
            r_pers <= vnoc_pkg::PERSISTENCE_RESET;
            r_oct  <= vnoc_pkg::OCTAVES_RESET;
        end else if (i_cfg_we) begin
            case (vnoc_pkg::t_cfg_reg'(i_cfg_idx))
                vnoc_pkg::CFG_ZOOM:        r_zoom <= i_cfg_data;
                vnoc_pkg::CFG_PERSISTENCE: r_pers <= i_cfg_data;
                vnoc_pkg::CFG_OCTAVES:     r_oct  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_z   = (r_zoom == 16'd0) ? 16'd1 : r_zoom;
    assign w_lim = ({1'b0, r_oct} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : {1'b0, r_oct};
    assign w_cnt = (w_lim == 6'd0) ? 6'd0 : (w_lim - 6'd1);

    vnoc_div #(.QW(QW), .SH(SH)) u_div_x (
        .i_clk(i_clk), .i_z(w_z), .i_p(i_px), .o_q(w_qx), .o_neg(w_nx)
    );
    vnoc_div #(.QW(QW), .SH(SH)) u_div_y (
        .i_clk(i_clk), .i_z(w_z), .i_p(i_py), .o_q(w_qy), .o_neg(w_ny)
    );

    // amplitude per octave; settles from persistence well inside divider latency
    assign w_amp[0] = vnoc_pkg::AMP_ONE;
    for (genvar ga = 1; ga < NO; ga++) begin : g_amp
        logic [46:0] w_prod;
        logic [32:0] w_sc;
        logic [30:0] r_amp;
        assign w_prod = w_amp[ga-1] * r_pers;
        assign w_sc   = w_prod[46:vnoc_pkg::AMP_FRAC];
        always_ff @(posedge i_clk) begin
            r_amp <= (w_sc > 33'(vnoc_pkg::AMP_CAP)) ? vnoc_pkg::AMP_CAP : w_sc[30:0];
        end
        assign w_amp[ga] = r_amp;
    end

    for (genvar go = 0; go < NO; go++) begin : g_oct
        vnoc_oct #(
            .F(F), .TB(COS_TABLE_BITS), .QW(QW), .SHR(MAX_OCTAVES - 2 - go),
            .CW(CW), .TW(TW)
        ) u_oct (
            .i_clk(i_clk), .i_qx(w_qx), .i_qy(w_qy), .i_nx(w_nx), .i_ny(w_ny),
            .i_amp(w_amp[go]), .i_en(6'(go) < w_cnt), .o_term(w_term[go])
        );
    end

    for (genvar gs = 0; gs < NO; gs++) begin : g_sum
        if (gs == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_acc[0] <= SW'(w_term[0]);
                r_tt[0]  <= w_term;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_acc[gs] <= r_acc[gs-1] + SW'(r_tt[gs-1][gs]);
                r_tt[gs]  <= r_tt[gs-1];
            end
        end
    end

    assign w_v = (VW'(r_acc[NO-1]) <<< 7) + (VW'(1) <<< (F + 7));
    assign w_q = w_v >>> F;

    always_ff @(posedge i_clk) begin
        if (w_v < 0) begin
            r_level <= 8'd0;
        end else if (w_q > VW'(255)) begin
            r_level <= 8'd255;
        end else begin
            r_level <= w_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_level = r_level;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("accepted pixel produced no level at the expected cycle");

    a_no_octave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_oct <= 5'd1)) |-> (o_level == 8'd128))
        else $error("level not mid-scale with no octave summed");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe out of reset");

endmodule

`default_nettype wire
